// ===== hw/rtl/jcmp_pkg.sv =====
`default_nettype none
package jcmp_pkg;
    localparam int unsigned FallbackMoveMs = 20;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;
    localparam logic [CfgIdxW-1:0] REG_FEED_XY = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FEED_Z = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ACCEL_X = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ACCEL_Y = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ACCEL_Z = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LEAD_MS = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_MIN_WAIT = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_MAX_WAIT = 3'd7;
    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X = 2'd1;
    localparam logic [1:0] AXIS_Y = 2'd2;
    localparam logic [1:0] AXIS_Z = 2'd3;
    localparam logic [0:0] KIND_CLICK = 1'b0;
    localparam logic [0:0] KIND_BATCH = 1'b1;

    typedef struct packed {
        logic start;
        logic [63:0] num;
        logic [47:0] den;
    } t_div_req;
endpackage
`default_nettype wire

// ===== hw/rtl/jog_click_move_planner.sv =====
`default_nettype none
// channel | dir | tdata (low bit up)                          | tuser | tlast
// s_axis  | in  | clicks[7:0], axis[9:8], step_size_um[26:10]  | kind  | -
// m_axis  | out | move_feed[15:0], move_clicks[47:16], wait_ms[63:48] | move_axis | -
// cfg     | in  | i_cfg_we, i_cfg_idx (3b), i_cfg_data (16b)   |       |
// A click beat leaves s_axis_tready high; so does a batch end without a move.
// A batch end with a move holds s_axis_tready low until its result is taken on
// m_axis: a serial multiply, then the fallback or huge-distance path, the triangle
// path (64-bit serial divide, then square root) or the trapezoid path (two 64-bit
// serial divides).
// Reset (synchronous, active low) loads register defaults and clears the total.
module jog_click_move_planner #(
    parameter int unsigned FALLBACK_MOVE_MS = jcmp_pkg::FallbackMoveMs
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // clicks, axis, step_size_um
    input  wire  [0:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // move_feed, move_clicks, wait_ms
    output logic [1:0]  m_axis_tuser,   // move_axis
    input  wire         i_cfg_we,
    input  wire  [jcmp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  wire  [jcmp_pkg::CfgDataW-1:0] i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_CHK = 4'd2, S_Q1 = 4'd3,
        S_Q1W = 4'd4, S_Q2 = 4'd5, S_Q2W = 4'd6, S_TRI = 4'd7, S_TRIW = 4'd8,
        S_SQRT = 4'd9, S_WAIT = 4'd10, S_OUT = 4'd11, S_CMP = 4'd12;

    logic [15:0] r_feed_xy, r_feed_z, r_ax, r_ay, r_az, r_min, r_max;
    logic [13:0] r_lead;
    logic signed [31:0] r_total, r_mv_clicks;
    logic [3:0]  r_st;
    logic [1:0]  r_axis;
    logic [15:0] r_f, r_a;
    logic [48:0] r_d;
    logic [31:0] r_mag;
    logic [16:0] r_step;
    logic [4:0]  r_cnt;
    logic [63:0] r_q1, r_t;
    logic [63:0] r_x, r_r, r_bit;
    logic [5:0]  r_scnt;
    logic        r_ov;
    logic [15:0] r_wait;
    logic        r_cmp_step;

    jcmp_pkg::t_div_req w_req;
    logic        w_done;
    logic [63:0] w_quot;

    jcmp_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
        .o_done(w_done), .o_quot(w_quot));

    wire [7:0]  w_clicks = s_axis_tdata[7:0];
    wire [1:0]  w_axis   = s_axis_tdata[9:8];
    wire [16:0] w_step   = s_axis_tdata[26:10];
    wire        w_acc    = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_st == S_IDLE);

    logic signed [32:0] w_sum;
    assign w_sum = {r_total[31], r_total} + {{25{w_clicks[7]}}, w_clicks};

    // trapezoid test products: 18*A*D and 5*F*F, narrow enough here (D < 2^36)
    logic [69:0] w_lhs;
    logic [34:0] w_rhs;
    assign w_lhs = 70'(r_a) * 70'(r_d[35:0]) * 70'd18;
    assign w_rhs = 35'(r_f) * 35'(r_f) * 35'd5;

    logic [64:0] w_sq_sum;
    assign w_sq_sum = {1'b0, r_r} + {1'b0, r_bit};

    logic signed [65:0] w_w;
    always_comb begin
        w_w = $signed({2'b0, r_t}) - $signed(66'(r_lead));
    end

    always_comb begin
        w_req.start = 1'b0; w_req.num = '0; w_req.den = '0;
        case (r_st)
            S_Q1: begin
                w_req.start = 1'b1; w_req.num = 64'({r_d[41:0] * 42'd60, 16'b0});
                w_req.den = 48'(r_f);
            end
            S_Q2: begin
                w_req.start = 1'b1; w_req.num = 64'(r_f) * 64'd50 << 16;
                w_req.den = 48'(r_a) * 48'd3;
            end
            S_TRI: begin
                w_req.start = 1'b1; w_req.num = 64'(r_d[35:0]) * 64'd4000;
                w_req.den = 48'(r_a);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_xy <= 16'd1000; r_feed_z <= 16'd500; r_ax <= 16'd500;
            r_ay <= 16'd500; r_az <= 16'd200; r_lead <= 14'd20;
            r_min <= 16'd10; r_max <= 16'd1000;
            r_total <= '0; r_st <= S_IDLE; m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    jcmp_pkg::REG_FEED_XY: r_feed_xy <= i_cfg_data;
                    jcmp_pkg::REG_FEED_Z:  r_feed_z <= i_cfg_data;
                    jcmp_pkg::REG_ACCEL_X: r_ax <= i_cfg_data;
                    jcmp_pkg::REG_ACCEL_Y: r_ay <= i_cfg_data;
                    jcmp_pkg::REG_ACCEL_Z: r_az <= i_cfg_data;
                    jcmp_pkg::REG_LEAD_MS: r_lead <= i_cfg_data[13:0];
                    jcmp_pkg::REG_MIN_WAIT: r_min <= i_cfg_data;
                    jcmp_pkg::REG_MAX_WAIT: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: if (w_acc) begin
                    if (s_axis_tuser == jcmp_pkg::KIND_CLICK) begin
                        if (w_sum > 33'sd2147483647) r_total <= 32'sh7fffffff;
                        else if (w_sum < -33'sd2147483648) r_total <= 32'sh80000000;
                        else r_total <= w_sum[31:0];
                    end else begin
                        r_total <= '0;
                        if (r_total != 0 && w_axis != jcmp_pkg::AXIS_NONE) begin
                            r_axis <= w_axis; r_mv_clicks <= r_total;
                            r_mag <= r_total[31] ? 32'(-r_total) : r_total;
                            r_step <= w_step; r_d <= '0; r_cnt <= '0;
                            r_f <= (w_axis == jcmp_pkg::AXIS_Z) ? r_feed_z : r_feed_xy;
                            r_a <= (w_axis == jcmp_pkg::AXIS_X) ? r_ax :
                                   (w_axis == jcmp_pkg::AXIS_Y) ? r_ay : r_az;
                            r_st <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    // shift-add, one multiplier bit of step per cycle
                    r_d <= {r_d[47:0], 1'b0} + (r_step[16] ? 49'(r_mag) : 49'd0);
                    r_step <= {r_step[15:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) r_st <= S_CHK;
                end
                S_CHK: begin
                    r_ov <= 1'b0;
                    if (r_d == 0 || r_f == 0 || r_a == 0) begin
                        r_t <= 64'(FALLBACK_MOVE_MS); r_st <= S_WAIT;
                    end else if (r_d[48:36] != 0) begin
                        r_t <= 64'd1 << 40; r_st <= S_WAIT;
                    end else if (w_lhs >= 70'(w_rhs)) r_st <= S_Q1;
                    else r_st <= S_TRI;
                end
                S_Q1:  r_st <= S_Q1W;
                S_Q1W: if (w_done) begin r_q1 <= w_quot; r_st <= S_Q2; end
                S_Q2:  r_st <= S_Q2W;
                S_Q2W: if (w_done) begin
                    r_t <= (r_q1 + w_quot) >> 16; r_st <= S_WAIT;
                end
                S_TRI:  r_st <= S_TRIW;
                S_TRIW: if (w_done) begin
                    r_x <= w_quot; r_r <= '0; r_bit <= 64'd1 << 62;
                    r_scnt <= '0; r_st <= S_SQRT;
                end
                S_SQRT: begin
                    // one result bit per cycle, 32 result bits in all
                    if (r_x >= w_sq_sum[63:0]) begin
                        r_x <= r_x - w_sq_sum[63:0];
                        r_r <= (r_r >> 1) + r_bit;
                    end else r_r <= r_r >> 1;
                    r_bit <= r_bit >> 2;
                    r_scnt <= r_scnt + 6'd1;
                    if (r_scnt == 6'd31) r_st <= S_CMP;
                end
                S_CMP: begin r_t <= r_r; r_st <= S_WAIT; end
                S_WAIT: begin
                    if (w_w < $signed(66'(r_min))) r_wait <= r_min;
                    else r_wait <= w_w[15:0];
                    r_cmp_step <= (w_w < $signed(66'(r_min))) ? 1'b0 :
                                  (w_w > $signed(66'(r_max)));
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!m_axis_tvalid && !r_ov) begin
                        m_axis_tvalid <= 1'b1; r_ov <= 1'b1;
                        m_axis_tdata <= {(r_cmp_step || r_wait > r_max) ? r_max : r_wait,
                                         r_mv_clicks, r_f};
                        m_axis_tuser <= r_axis;
                    end else if (m_axis_tvalid && m_axis_tready) begin
                        m_axis_tvalid <= 1'b0; r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result held");
    a_total_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && s_axis_tuser == jcmp_pkg::KIND_BATCH) |=> r_total == 0)
        else $error("total not cleared");
    a_axis_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != jcmp_pkg::AXIS_NONE) else $error("axis off");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/jcmp_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle; den must be nonzero
module jcmp_div (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  jcmp_pkg::t_div_req i_req,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic [63:0] r_q, n_q;
    logic [48:0] r_rem, n_rem;
    logic [47:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [48:0] w_sh;
    logic [49:0] w_diff;

    always_comb begin
        w_sh = {r_rem[47:0], r_q[63]};
        w_diff = {1'b0, w_sh} - {2'b0, r_den};
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_req.start) begin
            n_q = i_req.num; n_rem = '0; n_cnt = 7'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[49]) begin
                n_rem = w_diff[48:0]; n_q = {r_q[62:0], 1'b1};
            end else begin
                n_rem = w_sh; n_q = {r_q[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_cnt <= n_cnt;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire
